[hdl/c3f_pkg.sv]
// Shared types and constants for the 3x3 convolution stream filter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package c3f_pkg;

    // Field widths fixed by the interface.
    localparam int PIX_W      = 8;
    localparam int VAL_W      = 11;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int MODE_W     = 2;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Default sizes of the line stores and of the frame.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Register reset values.
    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = FW_W'(1024);
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = FH_W'(768);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Kernel select.
    typedef enum logic [MODE_W-1:0] {
        MODE_BLUR    = 2'd0,
        MODE_SHARPEN = 2'd1,
        MODE_SOBEL_X = 2'd2,
        MODE_SOBEL_Y = 2'd3
    } t_mode;

    // Position of one item and what it produces.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
    } t_pos;

endpackage

[hdl/c3f_pos_counter.sv]
// Column and row counters of the raster scan, with frame size saturation.
// Depends on c3f_pkg.
`timescale 1ns / 1ps

module c3f_pos_counter
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int ADDR_W     = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_frame_start,
    input  logic [FW_W-1:0]   i_frame_width,
    input  logic [FH_W-1:0]   i_frame_height,
    output logic [ADDR_W-1:0] o_addr,
    output t_pos              o_pos
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] col_raw, col;
    logic [ROW_W-1:0] row;
    logic [FW_W-1:0]  width_sat, width_m1;
    logic [FH_W-1:0]  height_sat, height_m1;
    logic             row_end, frame_end;

    // Frame size used, held between three and MAX_WIDTH columns and between three and MAX_HEIGHT rows.
    always_comb begin
        if (i_frame_width < FW_W'(3)) begin
            width_sat = FW_W'(3);
        end else if (32'(i_frame_width) > MAX_WIDTH) begin
            width_sat = FW_W'(MAX_WIDTH);
        end else begin
            width_sat = i_frame_width;
        end
        if (i_frame_height < FH_W'(3)) begin
            height_sat = FH_W'(3);
        end else if (32'(i_frame_height) > MAX_HEIGHT) begin
            height_sat = FH_W'(MAX_HEIGHT);
        end else begin
            height_sat = i_frame_height;
        end
        width_m1  = width_sat - FW_W'(1);
        height_m1 = height_sat - FH_W'(1);
    end

    // Position of the item now offered; a frame start restarts at the origin.
    always_comb begin
        col_raw = i_frame_start ? '0 : r_col;
        row     = i_frame_start ? '0 : r_row;
        if (32'(col_raw) >= MAX_WIDTH) begin
            col = COL_W'(MAX_WIDTH - 1);
        end else begin
            col = col_raw;
        end
        row_end   = {1'b0, col} >= width_m1;
        frame_end = {1'b0, row} >= height_m1;
    end

    assign o_addr           = ADDR_W'(col);
    assign o_pos.emit       = (row >= ROW_W'(2)) && (col >= COL_W'(2));
    assign o_pos.last       = row_end && frame_end;
    assign o_pos.centre_row = row - ROW_W'(1);
    assign o_pos.centre_col = col - COL_W'(1);

    // Advance along the row, wrapping to the next row and the next frame.
    always_comb begin
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : row + ROW_W'(1);
        end else begin
            n_col = col + COL_W'(1);
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

[hdl/c3f_line_buf.sv]
// The two line stores, held as one memory of {upper, lower} pixel pairs.
// A read of the column the previous item is writing takes the forwarded pair.
// Depends on c3f_pkg.
`timescale 1ns / 1ps

module c3f_line_buf
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]  i_wr_pix,
    output logic [PIX_W-1:0]  o_upper,
    output logic [PIX_W-1:0]  o_lower
);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [2*PIX_W-1:0] r_byp_data;
    logic               r_byp_hit;
    logic [2*PIX_W-1:0] pair;

    // The pair seen by the item in the stage after the read.
    assign pair    = r_byp_hit ? r_byp_data : r_rd_data;
    assign o_upper = pair[2*PIX_W-1:PIX_W];
    assign o_lower = pair[PIX_W-1:0];

    // Each column moves down one row: old lower becomes upper, new pixel lower.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {o_lower, i_wr_pix};
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= {o_lower, i_wr_pix};
        end
    end

endmodule

[hdl/c3f_window.sv]
// The 3x3 window of taps, the four kernels and the result register.
// Depends on c3f_pkg.
`timescale 1ns / 1ps

module c3f_window
    import c3f_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic                    i_step,
    input  t_mode                   i_mode,
    input  logic [PIX_W-1:0]        i_upper,
    input  logic [PIX_W-1:0]        i_lower,
    input  logic [PIX_W-1:0]        i_pix,
    input  t_pos                    i_pos,
    output logic                    o_out_valid,
    output logic signed [VAL_W-1:0] o_filtered_value,
    output logic [ROW_W-1:0]        o_centre_row,
    output logic [COL_W-1:0]        o_centre_col,
    output logic                    o_frame_last
);

    localparam int SUM_W = 13;

    logic [PIX_W-1:0]        r_tap [3][3];
    logic [PIX_W-1:0]        n_tap [3][3];
    logic signed [SUM_W-1:0] t [3][3];
    logic signed [SUM_W-1:0] blur_sum, sharp_sum, sobx_sum, soby_sum;
    logic signed [VAL_W-1:0] value;
    logic                    r_valid;
    logic signed [VAL_W-1:0] r_value;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic                    r_last;

    // Shift the window left and bring in the new column.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tap[i][0] = r_tap[i][1];
            n_tap[i][1] = r_tap[i][2];
        end
        n_tap[0][2] = i_upper;
        n_tap[1][2] = i_lower;
        n_tap[2][2] = i_pix;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                t[i][j] = $signed({{(SUM_W-PIX_W){1'b0}}, n_tap[i][j]});
            end
        end
    end

    // Kernel sums over the updated window.
    always_comb begin
        blur_sum  = t[0][0] + (t[0][1] <<< 1) + t[0][2]
                  + (t[1][0] <<< 1) + (t[1][1] <<< 2) + (t[1][2] <<< 1)
                  + t[2][0] + (t[2][1] <<< 1) + t[2][2];
        sharp_sum = (t[1][1] <<< 2) + t[1][1]
                  - t[0][1] - t[1][0] - t[1][2] - t[2][1];
        sobx_sum  = (t[0][0] + (t[1][0] <<< 1) + t[2][0])
                  - (t[0][2] + (t[1][2] <<< 1) + t[2][2]);
        soby_sum  = (t[0][0] + (t[0][1] <<< 1) + t[0][2])
                  - (t[2][0] + (t[2][1] <<< 1) + t[2][2]);
    end

    // Select the kernel; blur floors by sixteen, sharpen is clamped to a pixel.
    always_comb begin
        case (i_mode)
            MODE_BLUR: begin
                value = $signed({{(VAL_W-PIX_W){1'b0}}, blur_sum[PIX_W+3:4]});
            end
            MODE_SHARPEN: begin
                if (sharp_sum < 0) begin
                    value = '0;
                end else if (sharp_sum > 13'sd255) begin
                    value = 11'sd255;
                end else begin
                    value = sharp_sum[VAL_W-1:0];
                end
            end
            MODE_SOBEL_X: value = sobx_sum[VAL_W-1:0];
            MODE_SOBEL_Y: value = soby_sum[VAL_W-1:0];
            default:      value = '0;
        endcase
    end

    // Taps move once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_tap[i][j] <= '0;
                end
            end
        end else if (i_step) begin
            r_tap <= n_tap;
        end
    end

    // Result register; its valid flag is refilled whenever the pipeline advances, its data when an item steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_step && i_pos.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_value <= value;
            r_row   <= i_pos.centre_row;
            r_col   <= i_pos.centre_col;
            r_last  <= i_pos.last;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_filtered_value = r_value;
    assign o_centre_row     = r_row;
    assign o_centre_col     = r_col;
    assign o_frame_last     = r_last;

endmodule

[hdl/conv3x3_stream_filter.sv]
// Top level of the 3x3 convolution stream filter: configuration registers,
// the read stage and the wiring of counters, line stores and window.
// Depends on c3f_pkg, c3f_pos_counter, c3f_line_buf and c3f_window.
`timescale 1ns / 1ps

// Grey pixels enter in raster order, one item per clock while no held result
// is stalled, and each interior centre yields one filtered item, offered on
// the output once it has passed the read stage and the result register;
// border pixels yield nothing. The line stores are one memory with a
// registered read, read at the accepting edge and written back when the item
// leaves the read stage, which a stalled held result delays. A new pixel can
// therefore be taken on every cycle in which no waiting result is stalled.
// The line stores hold no reset value: until two full rows of a frame have
// passed, the rows above the frame are whatever was written last.

module conv3x3_stream_filter
    import c3f_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [PIX_W-1:0]        i_pixel_value,
    input  logic                    i_frame_start,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_filtered_value,
    output logic [ROW_W-1:0]        o_centre_row,
    output logic [COL_W-1:0]        o_centre_col,
    output logic                    o_frame_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    t_mode             r_mode;
    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic              advance, accept, step;
    logic [ADDR_W-1:0] rd_addr;
    t_pos              pos;
    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;
    t_pos              r_s1_pos;
    logic [PIX_W-1:0]  col_upper, col_lower;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_BLUR;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FILTER_MODE:  r_mode         <= t_mode'(i_cfg_wdata[MODE_W-1:0]);
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves unless a held result blocks it.
    assign advance    = !o_out_valid || !i_out_stall;
    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;
    assign step       = r_s1_valid && advance;

    c3f_pos_counter #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_frame_start  (i_frame_start),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_addr         (rd_addr),
        .o_pos          (pos)
    );

    // Read stage: holds the item while its line store pair is fetched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr <= rd_addr;
            r_s1_pix  <= i_pixel_value;
            r_s1_pos  <= pos;
        end
    end

    c3f_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .i_wr_en   (step),
        .i_wr_addr (r_s1_addr),
        .i_wr_pix  (r_s1_pix),
        .o_upper   (col_upper),
        .o_lower   (col_lower)
    );

    c3f_window u_window (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_step           (step),
        .i_mode           (r_mode),
        .i_upper          (col_upper),
        .i_lower          (col_lower),
        .i_pix            (r_s1_pix),
        .i_pos            (r_s1_pos),
        .o_out_valid      (o_out_valid),
        .o_filtered_value (o_filtered_value),
        .o_centre_row     (o_centre_row),
        .o_centre_col     (o_centre_col),
        .o_frame_last     (o_frame_last)
    );

`ifndef NO_ASSERTIONS
    // An accepted item always reaches the read stage.
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item did not reach the read stage");

    // A blocked read stage keeps its item and column.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("read stage lost its item while blocked");

    // A result only follows an item that left the read stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(step))
        else $error("result appeared without an item");

    // Results are never on the frame border.
    a_out_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_centre_row != '0) && (o_centre_col != '0)))
        else $error("result on the frame border");
`endif

endmodule
